// ===== rtl/tsfs_pkg.sv =====
// Types, widths, register indexes and per-channel next-state function of the
// turn-signal fade sequencer. No dependencies.
`default_nettype none

package tsfs_pkg;

    localparam int TIMER_BITS = 24;
    localparam int LEVEL_BITS = 16;
    localparam int CFG_IDX_BITS = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_UP_STEP       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DOWN_STEP     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOP_LEVEL     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UP_INTERVAL   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DOWN_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_TIME     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_TIME    = 3'd6;

    // register values after reset
    localparam logic [LEVEL_BITS-1:0] RST_UP_STEP       = 16'd100;
    localparam logic [LEVEL_BITS-1:0] RST_DOWN_STEP     = 16'd50;
    localparam logic [LEVEL_BITS-1:0] RST_TOP_LEVEL     = 16'd2000;
    localparam logic [TIMER_BITS-1:0] RST_UP_INTERVAL   = 24'd10000;
    localparam logic [TIMER_BITS-1:0] RST_DOWN_INTERVAL = 24'd7500;
    localparam logic [TIMER_BITS-1:0] RST_HOLD_TIME     = 24'd100000;
    localparam logic [TIMER_BITS-1:0] RST_PULSE_TIME    = 24'd100000;

    typedef struct packed {
        logic left_request_level;
        logic right_request_level;
    } t_in;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] left_pwm_level;
        logic [LEVEL_BITS-1:0] right_pwm_level;
        logic                  left_pulse_on;
        logic                  right_pulse_on;
    } t_out;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] up_step;
        logic [LEVEL_BITS-1:0] down_step;
        logic [LEVEL_BITS-1:0] top_level;
        logic [TIMER_BITS-1:0] up_interval;
        logic [TIMER_BITS-1:0] down_interval;
        logic [TIMER_BITS-1:0] hold_time;
        logic [TIMER_BITS-1:0] pulse_time;
    } t_cfg;

    // state of one lamp channel
    typedef struct packed {
        logic                  prev;
        logic                  active;
        logic                  rising;
        logic [LEVEL_BITS-1:0] level;
        logic [TIMER_BITS-1:0] step_cnt;
        logic [TIMER_BITS-1:0] pulse_cnt;
        logic                  pulse;
    } t_chan;

    // interval minus one, held at zero
    function automatic logic [TIMER_BITS-1:0] reload_of(input logic [TIMER_BITS-1:0] t);
        reload_of = (t == '0) ? '0 : t - TIMER_BITS'(1);
    endfunction

    // one tick of one channel
    function automatic t_chan chan_next(input t_chan s, input logic lvl, input t_cfg c);
        t_chan                 n;
        logic                  fell;
        logic [LEVEL_BITS:0]   sum;
        n    = s;
        fell = s.prev & ~lvl;
        n.prev = lvl;

        // start on a falling request edge while idle
        if (!s.active && fell) begin
            n.active    = 1'b1;
            n.pulse     = 1'b1;
            n.pulse_cnt = c.pulse_time;
            n.level     = c.up_step;
            n.step_cnt  = c.up_interval;
            n.rising    = 1'b1;
        end

        sum = {1'b0, n.level} + {1'b0, c.up_step};

        if (n.active) begin
            // front pulse timer
            if (n.pulse_cnt == '0) begin
                n.pulse = 1'b0;
            end else begin
                n.pulse_cnt = n.pulse_cnt - TIMER_BITS'(1);
            end

            // ramp timer and step
            if (n.step_cnt != '0) begin
                n.step_cnt = n.step_cnt - TIMER_BITS'(1);
            end else if (n.rising) begin
                if (sum >= {1'b0, c.top_level}) begin
                    n.level    = c.top_level;
                    n.rising   = 1'b0;
                    n.step_cnt = reload_of(c.hold_time);
                end else begin
                    n.level    = sum[LEVEL_BITS-1:0];
                    n.step_cnt = reload_of(c.up_interval);
                end
            end else if (c.down_step >= n.level) begin
                n.level  = '0;
                n.active = 1'b0;
            end else begin
                n.level    = n.level - c.down_step;
                n.step_cnt = reload_of(c.down_interval);
            end
        end
        chan_next = n;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/turn_signal_fade_sequencer.sv =====
// Top level of the turn-signal fade sequencer: input register, per-channel
// state update and result register. Depends on tsfs_pkg.
`default_nettype none

// Each request is one microsecond tick carrying both active-low request levels;
// each tick yields one result with both PWM levels and both front pulse flags.
// One tick is taken every clock cycle unless the input and result registers are
// both full and the result is not read. Each request goes from the input
// register through the combinational channel update, which runs both channels
// side by side, into the result register. Configuration writes are always
// ready and take effect on the next tick processed; write only while the block
// is idle.
module turn_signal_fade_sequencer (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // tick requests
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire tsfs_pkg::t_in                    i_in_data,
    // results
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output tsfs_pkg::t_out                        o_out_data,
    // configuration writes
    input  wire                                   i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire [tsfs_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire [tsfs_pkg::TIMER_BITS-1:0]        i_cfg_data
);

    tsfs_pkg::t_cfg     r_cfg;
    tsfs_pkg::t_in      r_in;
    logic               r_in_valid;
    tsfs_pkg::t_out     r_out;
    logic               r_out_valid;
    tsfs_pkg::t_chan    r_st [2];
    tsfs_pkg::t_chan    n_st [2];
    logic               n_adv;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.up_step       <= tsfs_pkg::RST_UP_STEP;
            r_cfg.down_step     <= tsfs_pkg::RST_DOWN_STEP;
            r_cfg.top_level     <= tsfs_pkg::RST_TOP_LEVEL;
            r_cfg.up_interval   <= tsfs_pkg::RST_UP_INTERVAL;
            r_cfg.down_interval <= tsfs_pkg::RST_DOWN_INTERVAL;
            r_cfg.hold_time     <= tsfs_pkg::RST_HOLD_TIME;
            r_cfg.pulse_time    <= tsfs_pkg::RST_PULSE_TIME;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tsfs_pkg::CFG_UP_STEP:
                    r_cfg.up_step <= i_cfg_data[tsfs_pkg::LEVEL_BITS-1:0];
                tsfs_pkg::CFG_DOWN_STEP:
                    r_cfg.down_step <= i_cfg_data[tsfs_pkg::LEVEL_BITS-1:0];
                tsfs_pkg::CFG_TOP_LEVEL:
                    r_cfg.top_level <= i_cfg_data[tsfs_pkg::LEVEL_BITS-1:0];
                tsfs_pkg::CFG_UP_INTERVAL:   r_cfg.up_interval   <= i_cfg_data;
                tsfs_pkg::CFG_DOWN_INTERVAL: r_cfg.down_interval <= i_cfg_data;
                tsfs_pkg::CFG_HOLD_TIME:     r_cfg.hold_time     <= i_cfg_data;
                tsfs_pkg::CFG_PULSE_TIME:    r_cfg.pulse_time    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow: the input stage moves on when the result slot frees up
    assign n_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // channel updates, left and right side by side
    always_comb begin
        n_st[0] = tsfs_pkg::chan_next(r_st[0], r_in.left_request_level, r_cfg);
        n_st[1] = tsfs_pkg::chan_next(r_st[1], r_in.right_request_level, r_cfg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                r_st[c] <= '{prev: 1'b1, default: '0};
            end
        end else if (n_adv) begin
            r_st[0] <= n_st[0];
            r_st[1] <= n_st[1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (n_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_out.left_pwm_level  <= n_st[0].level;
            r_out.right_pwm_level <= n_st[1].level;
            r_out.left_pulse_on   <= n_st[0].pulse;
            r_out.right_pulse_on  <= n_st[1].pulse;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a tick in the input stage reaches an empty result slot next cycle
    a_move_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |=> r_out_valid)
        else $error("input stage did not advance into free result slot");

    // channel state only changes when a tick is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !n_adv |=> $stable(r_st[0]) && $stable(r_st[1]))
        else $error("channel state changed without a tick");

    // a channel only starts on a low request level
    a_left_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_st[0].active) |-> !r_st[0].prev)
        else $error("left channel started without falling request");

    a_right_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_st[1].active) |-> !r_st[1].prev)
        else $error("right channel started without falling request");
`endif

endmodule

`default_nettype wire

// ===== sim/turn_signal_fade_sequencer_tb.sv =====
// Self-checking testbench for the turn-signal fade sequencer: drives request ticks
// and register writes, predicts every result and checks it field by field.
// Depends on tsfs_pkg and turn_signal_fade_sequencer.
`timescale 1ns / 100ps

module turn_signal_fade_sequencer_tb;

    // unmapped index, write is dropped
    localparam logic [tsfs_pkg::CFG_IDX_BITS-1:0] CFG_NONE = 3'd7;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_TICKS = 70;

    // Predicts the lamp outputs of both channels and queues them until the
    // block returns the matching result.
    class fade_tracker;
        tsfs_pkg::t_cfg                  regs;
        bit                              prev[2];
        bit                              active[2];
        bit                              rising[2];
        bit                              pulse[2];
        logic [tsfs_pkg::LEVEL_BITS-1:0] level[2];
        logic [tsfs_pkg::TIMER_BITS-1:0] step_cnt[2];
        logic [tsfs_pkg::TIMER_BITS-1:0] pulse_cnt[2];
        tsfs_pkg::t_out                  expected_lamps[$];
        int                              errors;
        int                              ticks;
        int                              starts;

        function new();
            regs = '{up_step: tsfs_pkg::RST_UP_STEP,
                     down_step: tsfs_pkg::RST_DOWN_STEP,
                     top_level: tsfs_pkg::RST_TOP_LEVEL,
                     up_interval: tsfs_pkg::RST_UP_INTERVAL,
                     down_interval: tsfs_pkg::RST_DOWN_INTERVAL,
                     hold_time: tsfs_pkg::RST_HOLD_TIME,
                     pulse_time: tsfs_pkg::RST_PULSE_TIME};
            for (int c = 0; c < 2; c++) begin
                prev[c]      = 1'b1;
                active[c]    = 1'b0;
                rising[c]    = 1'b0;
                pulse[c]     = 1'b0;
                level[c]     = '0;
                step_cnt[c]  = '0;
                pulse_cnt[c] = '0;
            end
        endfunction

        function void write_reg(logic [tsfs_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [tsfs_pkg::TIMER_BITS-1:0] d);
            case (idx)
                tsfs_pkg::CFG_UP_STEP:
                    regs.up_step       = d[tsfs_pkg::LEVEL_BITS-1:0];
                tsfs_pkg::CFG_DOWN_STEP:
                    regs.down_step     = d[tsfs_pkg::LEVEL_BITS-1:0];
                tsfs_pkg::CFG_TOP_LEVEL:
                    regs.top_level     = d[tsfs_pkg::LEVEL_BITS-1:0];
                tsfs_pkg::CFG_UP_INTERVAL:   regs.up_interval   = d;
                tsfs_pkg::CFG_DOWN_INTERVAL: regs.down_interval = d;
                tsfs_pkg::CFG_HOLD_TIME:     regs.hold_time     = d;
                tsfs_pkg::CFG_PULSE_TIME:    regs.pulse_time    = d;
                default: ;
            endcase
        endfunction

        // countdown reload: one less than the interval, never below zero
        function logic [tsfs_pkg::TIMER_BITS-1:0] interval_reload(
                logic [tsfs_pkg::TIMER_BITS-1:0] t);
            return (t == '0) ? '0 : t - 1'b1;
        endfunction

        // one tick of one lamp channel
        function void advance_channel(int c, bit lvl);
            bit                            fell;
            logic [tsfs_pkg::LEVEL_BITS:0] sum;
            fell    = prev[c] && !lvl;
            prev[c] = lvl;

            // falling request edge on an idle channel starts it
            if (!active[c] && fell) begin
                active[c]    = 1'b1;
                pulse[c]     = 1'b1;
                pulse_cnt[c] = regs.pulse_time;
                level[c]     = regs.up_step;
                step_cnt[c]  = regs.up_interval;
                rising[c]    = 1'b1;
                starts++;
            end
            if (!active[c])
                return;

            // front pulse times out only while active
            if (pulse_cnt[c] == '0)
                pulse[c] = 1'b0;
            else
                pulse_cnt[c]--;

            if (step_cnt[c] != '0) begin
                step_cnt[c]--;
            end else if (rising[c]) begin
                sum = {1'b0, level[c]} + {1'b0, regs.up_step};
                if (sum >= {1'b0, regs.top_level}) begin
                    // clamp at top, then hold
                    level[c]    = regs.top_level;
                    rising[c]   = 1'b0;
                    step_cnt[c] = interval_reload(regs.hold_time);
                end else begin
                    level[c]    = sum[tsfs_pkg::LEVEL_BITS-1:0];
                    step_cnt[c] = interval_reload(regs.up_interval);
                end
            end else if (regs.down_step >= level[c]) begin
                // fall ends at zero and the channel goes idle
                level[c]  = '0;
                active[c] = 1'b0;
            end else begin
                level[c]    = level[c] - regs.down_step;
                step_cnt[c] = interval_reload(regs.down_interval);
            end
        endfunction

        function void note_tick(tsfs_pkg::t_in req);
            tsfs_pkg::t_out lamps;
            advance_channel(0, req.left_request_level);
            advance_channel(1, req.right_request_level);
            lamps.left_pwm_level  = level[0];
            lamps.right_pwm_level = level[1];
            lamps.left_pulse_on   = pulse[0];
            lamps.right_pulse_on  = pulse[1];
            expected_lamps.push_back(lamps);
            ticks++;
        endfunction

        function int pending();
            return expected_lamps.size();
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $time, what);
            errors++;
        endtask

        task check_lamps(tsfs_pkg::t_out got);
            tsfs_pkg::t_out want;
            if (expected_lamps.size() == 0) begin
                report($sformatf("result %h with no request outstanding", got));
                return;
            end
            want = expected_lamps.pop_front();
            if (got.left_pwm_level !== want.left_pwm_level)
                report($sformatf("left_pwm_level %0d, predicted %0d",
                                 got.left_pwm_level, want.left_pwm_level));
            if (got.right_pwm_level !== want.right_pwm_level)
                report($sformatf("right_pwm_level %0d, predicted %0d",
                                 got.right_pwm_level, want.right_pwm_level));
            if (got.left_pulse_on !== want.left_pulse_on)
                report($sformatf("left_pulse_on %b, predicted %b",
                                 got.left_pulse_on, want.left_pulse_on));
            if (got.right_pulse_on !== want.right_pulse_on)
                report($sformatf("right_pulse_on %b, predicted %b",
                                 got.right_pulse_on, want.right_pulse_on));
        endtask
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_ready;
    tsfs_pkg::t_in                     i_in_data;
    logic                              o_out_valid;
    logic                              i_out_ready;
    tsfs_pkg::t_out                    o_out_data;
    logic                              i_cfg_valid;
    logic                              o_cfg_ready;
    logic [tsfs_pkg::CFG_IDX_BITS-1:0] i_cfg_index;
    logic [tsfs_pkg::TIMER_BITS-1:0]   i_cfg_data;

    fade_tracker sb;
    bit          quiet;        // no idling on either side
    int          settings;
    int          stall_left;
    bit          held_level[2];
    int          run_left[2];

    turn_signal_fade_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout: block stopped making progress");
        $display("CHECKS FAILED");
        $finish;
    end

    // handshake monitor: all three channels sampled at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready)
                sb.note_tick(i_in_data);
            if (o_out_valid && i_out_ready)
                sb.check_lamps(o_out_data);
        end
    end

    // result side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 15);
        end
    end

    // one tick request; valid stays up across back-to-back requests
    task send_tick(tsfs_pkg::t_in req);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task send_pair(bit left, bit right);
        send_tick('{left_request_level: left, right_request_level: right});
    endtask

    // stop sending and wait until every predicted result is back
    task settle_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(logic [tsfs_pkg::CFG_IDX_BITS-1:0] idx,
                   logic [tsfs_pkg::TIMER_BITS-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // 16-bit registers get junk in the unused upper data bits
    task load_regs(tsfs_pkg::t_cfg v);
        write_reg(tsfs_pkg::CFG_UP_STEP, {8'($urandom), v.up_step});
        write_reg(tsfs_pkg::CFG_DOWN_STEP, {8'($urandom), v.down_step});
        write_reg(tsfs_pkg::CFG_TOP_LEVEL, {8'($urandom), v.top_level});
        write_reg(tsfs_pkg::CFG_UP_INTERVAL, v.up_interval);
        write_reg(tsfs_pkg::CFG_DOWN_INTERVAL, v.down_interval);
        write_reg(tsfs_pkg::CFG_HOLD_TIME, v.hold_time);
        write_reg(tsfs_pkg::CFG_PULSE_TIME, v.pulse_time);
        write_reg(CFG_NONE, 24'($urandom));
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    // mostly short ramps so whole rise/hold/fall cycles fit in a phase
    function automatic tsfs_pkg::t_cfg random_settings();
        tsfs_pkg::t_cfg v;
        int             up;
        int             tp;
        if ($urandom_range(0, 5) == 0) begin
            v.up_step   = tsfs_pkg::LEVEL_BITS'($urandom_range(1, 65535));
            v.down_step = tsfs_pkg::LEVEL_BITS'($urandom_range(1, 65535));
            v.top_level = tsfs_pkg::LEVEL_BITS'($urandom_range(1, 65535));
        end else begin
            up          = $urandom_range(100, 1500);
            tp          = up * $urandom_range(1, 8) + $urandom_range(0, up - 1);
            v.up_step   = tsfs_pkg::LEVEL_BITS'(up);
            v.top_level = tsfs_pkg::LEVEL_BITS'(tp);
            v.down_step = tsfs_pkg::LEVEL_BITS'($urandom_range(tp / 8 + 1, tp));
        end
        v.up_interval   = tsfs_pkg::TIMER_BITS'($urandom_range(1, 4));
        v.down_interval = tsfs_pkg::TIMER_BITS'($urandom_range(1, 4));
        v.hold_time     = tsfs_pkg::TIMER_BITS'($urandom_range(1, 10));
        v.pulse_time    = tsfs_pkg::TIMER_BITS'($urandom_range(1, 150));
        return v;
    endfunction

    // request levels held for random runs, with occasional one-tick glitches
    function automatic tsfs_pkg::t_in next_request();
        tsfs_pkg::t_in req;
        bit            lv[2];
        for (int c = 0; c < 2; c++) begin
            if (run_left[c] == 0) begin
                held_level[c] = ~held_level[c];
                run_left[c]   = held_level[c] ? $urandom_range(1, 20) : $urandom_range(1, 10);
            end else begin
                run_left[c]--;
            end
            lv[c] = ($urandom_range(0, 9) == 0) ? 1'($urandom) : held_level[c];
        end
        req.left_request_level  = lv[0];
        req.right_request_level = lv[1];
        return req;
    endfunction

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '{left_request_level: 1'b1, right_request_level: 1'b1};
        i_out_ready <= 1'b1;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= tsfs_pkg::CFG_UP_STEP;
        i_cfg_data  <= '0;
        quiet         = 1'b0;
        settings      = 0;
        held_level[0] = 1'b1;
        held_level[1] = 1'b1;
        run_left[0]   = 0;
        run_left[1]   = 0;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // outputs straight out of reset, requests released
        send_pair(1'b1, 1'b1);
        send_pair(1'b1, 1'b1);
        settle_results();

        // full-scale steps: rising sum overflows 16 bits, fall ends in one step
        load_regs('{up_step: 16'hFFFF, down_step: 16'hFFFF, top_level: 16'hFFFF,
                    up_interval: 24'd1, down_interval: 24'd1, hold_time: 24'd1,
                    pulse_time: 24'd1});
        send_pair(1'b0, 1'b0);
        send_pair(1'b0, 1'b1);
        send_pair(1'b1, 1'b0);
        send_pair(1'b0, 1'b0);
        send_pair(1'b1, 1'b1);
        send_pair(1'b1, 1'b1);
        send_pair(1'b0, 1'b0);
        settle_results();

        // start level above top, zero intervals: step and pulse clear on start tick
        load_regs('{up_step: 16'd500, down_step: 16'd1, top_level: 16'd1,
                    up_interval: 24'd0, down_interval: 24'd0, hold_time: 24'd0,
                    pulse_time: 24'd0});
        send_pair(1'b1, 1'b0);
        send_pair(1'b0, 1'b1);
        send_pair(1'b1, 1'b0);
        send_pair(1'b0, 1'b1);
        send_pair(1'b1, 1'b1);
        settle_results();

        // unit steps with a pulse that outlives the ramp; edges while active
        load_regs('{up_step: 16'd1, down_step: 16'd1, top_level: 16'd3,
                    up_interval: 24'd1, down_interval: 24'd1, hold_time: 24'd2,
                    pulse_time: 24'hFFFFFF});
        for (int k = 0; k < 10; k++)
            send_pair(k[0], k[1]);
        settle_results();

        // random settings, random request traffic
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            load_regs(random_settings());
            if (ph == RANDOM_PHASES - 1)
                quiet = 1'b1;
            for (int i = 0; i < PHASE_TICKS; i++) begin
                if (ph == 2 && i == PHASE_TICKS / 2)
                    settle_results();
                send_tick(next_request());
            end
            settle_results();
        end

        // largest register values everywhere
        load_regs('{up_step: 16'hFFFF, down_step: 16'hFFFF, top_level: 16'hFFFF,
                    up_interval: 24'hFFFFFF, down_interval: 24'hFFFFFF,
                    hold_time: 24'hFFFFFF, pulse_time: 24'hFFFFFF});
        for (int k = 0; k < 8; k++)
            send_pair(k[1], k[0]);
        settle_results();

        $display("Run covered %0d ticks and %0d lamp starts over %0d register settings",
                 sb.ticks, sb.starts, settings);
        $display("Mismatches found: %0d", sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
